[hdl/quic_frame_parser_top_macros.svh]
// Assertion macros shared by the checker.
`ifndef QUIC_FRAME_PARSER_TOP_MACROS_SVH
`define QUIC_FRAME_PARSER_TOP_MACROS_SVH
`define QFP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define QFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[hdl/qfp_pkg.sv]
`default_nettype none
package qfp_pkg;
    localparam int unsigned ValW = 62;

    typedef enum logic [1:0] {
        K_HDR  = 2'd0,
        K_DATA = 2'd1,
        K_DONE = 2'd2,
        K_ERR  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        E_NONE  = 2'd0,
        E_TRUNC = 2'd1,
        E_UNK   = 2'd2
    } t_err;

    // The raw-byte phases have the highest codes, so one compare separates them.
    typedef enum logic [21:0] {
        P_TYPE        = 22'h000001,
        P_ACK_LARGEST = 22'h000002,
        P_ACK_DELAY   = 22'h000004,
        P_ACK_COUNT   = 22'h000008,
        P_ACK_FIRST   = 22'h000010,
        P_SKIPVARS    = 22'h000020,
        P_CRYPTO_OFF  = 22'h000040,
        P_CRYPTO_LEN  = 22'h000080,
        P_STREAM_ID   = 22'h000100,
        P_STREAM_OFF  = 22'h000200,
        P_STREAM_LEN  = 22'h000400,
        P_MAXDATA     = 22'h000800,
        P_CC_ERR      = 22'h001000,
        P_CC_FT       = 22'h002000,
        P_CC_RLEN     = 22'h004000,
        P_TOKLEN      = 22'h008000,
        P_NCID_SEQ    = 22'h010000,
        P_NCID_RET    = 22'h020000,
        P_NCID_CIDLEN = 22'h040000,
        P_SKIPBYTES   = 22'h080000,
        P_DATA        = 22'h100000,
        P_DATA_OPEN   = 22'h200000
    } t_phase;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       packet_end;
    } t_in;

    typedef struct packed {
        t_kind           kind;
        logic [4:0]      ftype;
        logic [ValW-1:0] field_a;
        logic [ValW-1:0] field_b;
        logic [ValW-1:0] field_c;
        logic [ValW-1:0] field_d;
        logic            stream_fin;
        logic            close_app;
        logic            length_open;
        logic [7:0]      data_byte;
        t_err            err_code;
        logic            last;
    } t_res;

    // One byte yields at most two results.
    typedef struct packed {
        logic [1:0] cnt;
        t_res       r0;
        t_res       r1;
    } t_pair;
endpackage
`default_nettype wire

[hdl/qfp_if.sv]
`default_nettype none
interface qfp_in_if;
    logic          valid;
    logic          ready;
    qfp_pkg::t_in  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface qfp_out_if;
    logic          valid;
    logic          ready;
    qfp_pkg::t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/quic_frame_parser_top.sv]
// QUIC frame parser. Input channel i_in carries one payload byte per item with
// a packet_end flag; output channel o_out carries result items (header, data,
// done, error), each with last set on the final result of its input byte.
// The front decoder is combinational: an accepted byte's results are written into
// the result queue as it is accepted and reach o_out once earlier results drain.
// Throughput is one byte per cycle while each byte gives at most one result
// and the receiver is ready; a byte giving two results needs two transfers on
// o_out, and the queue of QueueDepth entries absorbs such bursts. The front
// stops accepting when the queue has fewer than two free entries.
// When the receiver stalls, results wait in the queue and i_in.ready falls
// once it fills; nothing is lost.
// Reset clears the parser to wait for a frame type and empties the queue.
`default_nettype none
module quic_frame_parser_top #(
    parameter int unsigned QueueDepth = 4
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    qfp_in_if.sink     i_in,
    qfp_out_if.source  o_out
);
    logic           q_valid, q_ready;
    qfp_pkg::t_pair q_data;

    qfp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in),
        .i_q_ready(q_ready), .o_q_valid(q_valid), .o_q_data(q_data)
    );

    qfp_back #(.Depth(QueueDepth)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid), .i_q_data(q_data),
        .o_q_ready(q_ready), .o_out(o_out)
    );
endmodule
`default_nettype wire

[hdl/qfp_front.sv]
`default_nettype none
module qfp_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    qfp_in_if.sink           i_in,
    input  wire              i_q_ready,
    output logic             o_q_valid,
    output qfp_pkg::t_pair   o_q_data
);
    qfp_pkg::t_phase r_phase, n_phase;
    logic [61:0] r_vv, n_vv;
    logic [2:0]  r_vleft, n_vleft;
    logic [4:0]  r_type, n_type;
    logic [61:0] r_a, n_a, r_b, n_b, r_c, n_c, r_d, n_d;
    logic [63:0] r_skip, n_skip;
    logic        r_drop, n_drop;

    logic [7:0]  b;
    logic        pe, acc;
    logic [1:0]  cnt;
    qfp_pkg::t_res res0, res1;

    assign i_in.ready = i_q_ready;
    assign acc        = i_in.valid && i_in.ready;
    assign b          = i_in.data.byte_value;
    assign pe         = i_in.data.packet_end;

    function automatic qfp_pkg::t_res mk(input qfp_pkg::t_kind k, input logic [4:0] t,
                                         input logic [61:0] a, input logic [61:0] bb,
                                         input logic [61:0] c, input logic [61:0] d,
                                         input logic [7:0] db, input qfp_pkg::t_err e);
        qfp_pkg::t_res r;
        logic hdr, strm;
        hdr  = (k == qfp_pkg::K_HDR);
        strm = (t >= 5'd8) && (t <= 5'h0f);
        r = '0;
        r.kind        = k;
        r.ftype       = t;
        r.field_a     = hdr ? a : '0;
        r.field_b     = hdr ? bb : '0;
        r.field_c     = hdr ? c : '0;
        r.field_d     = hdr ? d : '0;
        r.stream_fin  = hdr && strm && t[0];
        r.close_app   = hdr && (t == 5'h1d);
        r.length_open = hdr && strm && !t[1];
        r.data_byte   = db;
        r.err_code    = e;
        return r;
    endfunction

    always_comb begin
        logic [61:0] v;
        logic        complete, st_done, st_unk, hdr_now;
        logic [63:0] sk;
        logic        do_skip;
        logic [4:0]  t;
        n_phase = r_phase; n_vv = r_vv; n_vleft = r_vleft; n_type = r_type;
        n_a = r_a; n_b = r_b; n_c = r_c; n_d = r_d; n_skip = r_skip; n_drop = r_drop;
        cnt = 2'd0; res0 = '0; res1 = '0;
        st_done = 1'b0; st_unk = 1'b0; hdr_now = 1'b0;
        sk = '0; do_skip = 1'b0; v = '0; complete = 1'b0; t = r_type;
        if (r_drop) begin
            if (pe) begin
                n_drop = 1'b0;
                n_phase = qfp_pkg::P_TYPE; n_vv = '0; n_vleft = '0; n_type = '0;
                n_a = '0; n_b = '0; n_c = '0; n_d = '0; n_skip = '0;
            end
        end else begin
            if (r_phase < qfp_pkg::P_NCID_CIDLEN) begin
                if (r_vleft == 3'd0) begin
                    n_vleft = 3'((4'd1 << b[7:6]) - 4'd1);
                    v = {56'd0, b[5:0]};
                end else begin
                    v = {r_vv[53:0], b};
                    n_vleft = r_vleft - 3'd1;
                end
                n_vv = v;
                complete = (n_vleft == 3'd0);
                if (complete) begin
                    case (r_phase)
                        qfp_pkg::P_TYPE: begin
                            t = (v > 62'd31) ? 5'd31 : v[4:0];
                            n_type = t;
                            if (v > 62'h1e) st_unk = 1'b1;
                            else begin
                                case (t)
                                    5'h00, 5'h01, 5'h1e: begin
                                        hdr_now = 1'b1; st_done = 1'b1;
                                    end
                                    5'h02, 5'h03: n_phase = qfp_pkg::P_ACK_LARGEST;
                                    5'h06: n_phase = qfp_pkg::P_CRYPTO_OFF;
                                    5'h10: n_phase = qfp_pkg::P_MAXDATA;
                                    5'h1c, 5'h1d: n_phase = qfp_pkg::P_CC_ERR;
                                    5'h08, 5'h09, 5'h0a, 5'h0b, 5'h0c, 5'h0d, 5'h0e,
                                    5'h0f: n_phase = qfp_pkg::P_STREAM_ID;
                                    5'h04: begin hdr_now = 1'b1; do_skip = 1'b1; sk = 64'd3; end
                                    5'h05, 5'h11, 5'h15: begin
                                        hdr_now = 1'b1; do_skip = 1'b1; sk = 64'd2;
                                    end
                                    5'h07: begin hdr_now = 1'b1; n_phase = qfp_pkg::P_TOKLEN; end
                                    5'h18: begin hdr_now = 1'b1; n_phase = qfp_pkg::P_NCID_SEQ; end
                                    5'h1a, 5'h1b: begin
                                        hdr_now = 1'b1; sk = 64'd8;
                                        n_skip = sk; n_phase = qfp_pkg::P_SKIPBYTES;
                                    end
                                    default: begin hdr_now = 1'b1; do_skip = 1'b1; sk = 64'd1; end
                                endcase
                            end
                        end
                        qfp_pkg::P_ACK_LARGEST: begin n_a = v; n_phase = qfp_pkg::P_ACK_DELAY; end
                        qfp_pkg::P_ACK_DELAY: begin n_b = v; n_phase = qfp_pkg::P_ACK_COUNT; end
                        qfp_pkg::P_ACK_COUNT: begin n_c = v; n_phase = qfp_pkg::P_ACK_FIRST; end
                        qfp_pkg::P_ACK_FIRST: begin
                            n_d = v; hdr_now = 1'b1; do_skip = 1'b1;
                            sk = {1'b0, r_c, 1'b0} + ((r_type == 5'd3) ? 64'd3 : 64'd0);
                        end
                        qfp_pkg::P_SKIPVARS: begin
                            n_skip = r_skip - 64'd1;
                            st_done = (n_skip == 64'd0);
                        end
                        qfp_pkg::P_CRYPTO_OFF: begin n_a = v; n_phase = qfp_pkg::P_CRYPTO_LEN; end
                        qfp_pkg::P_STREAM_ID: begin
                            n_a = v;
                            if (r_type[2]) n_phase = qfp_pkg::P_STREAM_OFF;
                            else if (r_type[1]) n_phase = qfp_pkg::P_STREAM_LEN;
                            else begin hdr_now = 1'b1; n_phase = qfp_pkg::P_DATA_OPEN; end
                        end
                        qfp_pkg::P_STREAM_OFF: begin
                            n_b = v;
                            if (r_type[1]) n_phase = qfp_pkg::P_STREAM_LEN;
                            else begin hdr_now = 1'b1; n_phase = qfp_pkg::P_DATA_OPEN; end
                        end
                        qfp_pkg::P_CRYPTO_LEN, qfp_pkg::P_STREAM_LEN,
                        qfp_pkg::P_CC_RLEN: begin
                            n_c = v; hdr_now = 1'b1;
                            if (v == 62'd0) st_done = 1'b1;
                            else begin n_skip = {2'b0, v}; n_phase = qfp_pkg::P_DATA; end
                        end
                        qfp_pkg::P_MAXDATA: begin n_a = v; hdr_now = 1'b1; st_done = 1'b1; end
                        qfp_pkg::P_CC_ERR: begin
                            n_a = v;
                            n_phase = (r_type == 5'h1c) ? qfp_pkg::P_CC_FT : qfp_pkg::P_CC_RLEN;
                        end
                        qfp_pkg::P_CC_FT: begin n_b = v; n_phase = qfp_pkg::P_CC_RLEN; end
                        qfp_pkg::P_TOKLEN: begin
                            if (v == 62'd0) st_done = 1'b1;
                            else begin n_skip = {2'b0, v}; n_phase = qfp_pkg::P_SKIPBYTES; end
                        end
                        qfp_pkg::P_NCID_SEQ: n_phase = qfp_pkg::P_NCID_RET;
                        default: n_phase = qfp_pkg::P_NCID_CIDLEN;
                    endcase
                    if (do_skip) begin
                        if (sk == 64'd0) st_done = 1'b1;
                        else begin n_skip = sk; n_phase = qfp_pkg::P_SKIPVARS; end
                    end
                end
            end else if (r_phase == qfp_pkg::P_NCID_CIDLEN) begin
                n_skip = {56'd0, b} + 64'd16; n_phase = qfp_pkg::P_SKIPBYTES;
            end else if (r_phase == qfp_pkg::P_SKIPBYTES) begin
                n_skip = r_skip - 64'd1; st_done = (n_skip == 64'd0);
            end else begin
                res0 = mk(qfp_pkg::K_DATA, r_type, '0, '0, '0, '0, b, qfp_pkg::E_NONE);
                cnt = 2'd1;
                if (r_phase == qfp_pkg::P_DATA) begin
                    n_skip = r_skip - 64'd1; st_done = (n_skip == 64'd0);
                end
            end
            if (hdr_now) begin
                res0 = mk(qfp_pkg::K_HDR, t, n_a, n_b, n_c, n_d, 8'd0, qfp_pkg::E_NONE);
                cnt = 2'd1;
            end
            if (st_unk || st_done || pe) begin
                if (st_unk) res1 = mk(qfp_pkg::K_ERR, t, '0, '0, '0, '0, 8'd0, qfp_pkg::E_UNK);
                else if (st_done || n_phase == qfp_pkg::P_DATA_OPEN)
                    res1 = mk(qfp_pkg::K_DONE, t, '0, '0, '0, '0, 8'd0, qfp_pkg::E_NONE);
                else begin
                    res1 = mk(qfp_pkg::K_ERR, t, '0, '0, '0, '0, 8'd0, qfp_pkg::E_TRUNC);
                end
                if (cnt == 2'd0) res0 = res1;
                cnt = cnt + 2'd1;
                n_phase = qfp_pkg::P_TYPE; n_vv = '0; n_vleft = '0; n_type = '0;
                n_a = '0; n_b = '0; n_c = '0; n_d = '0; n_skip = '0;
                if (st_unk && !pe) n_drop = 1'b1;
            end
            if (cnt == 2'd1) res0.last = 1'b1;
            res1.last = 1'b1;
        end
    end

    assign o_q_valid     = acc && (cnt != 2'd0);
    assign o_q_data.cnt  = cnt;
    assign o_q_data.r0   = res0;
    assign o_q_data.r1   = res1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= qfp_pkg::P_TYPE; r_vv <= '0; r_vleft <= '0; r_type <= '0;
            r_a <= '0; r_b <= '0; r_c <= '0; r_d <= '0; r_skip <= '0; r_drop <= 1'b0;
        end else if (acc) begin
            r_phase <= n_phase; r_vv <= n_vv; r_vleft <= n_vleft; r_type <= n_type;
            r_a <= n_a; r_b <= n_b; r_c <= n_c; r_d <= n_d; r_skip <= n_skip;
            r_drop <= n_drop;
        end
    end
endmodule
`default_nettype wire

[hdl/qfp_back.sv]
`default_nettype none
module qfp_back #(
    parameter int unsigned Depth = 4
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_q_valid,
    input  qfp_pkg::t_pair  i_q_data,
    output logic            o_q_ready,
    qfp_out_if.source       o_out
);
    localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
    qfp_pkg::t_pair r_mem [Depth];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;
    logic           r_sub;
    qfp_pkg::t_pair head;
    logic           push, pop, empty;

    assign empty       = (r_cnt == '0);
    assign head        = r_mem[r_rp];
    assign o_q_ready   = (r_cnt < (AW+1)'(Depth - 1));
    assign push        = i_q_valid;
    assign o_out.valid = !empty;
    assign o_out.data  = r_sub ? head.r1 : head.r0;
    assign pop         = o_out.valid && o_out.ready && (r_sub || head.cnt == 2'd1);

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_q_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; r_sub <= 1'b0;
        end else begin
            if (push) r_wp <= (r_wp == AW'(Depth - 1)) ? '0 : r_wp + 1'b1;
            if (pop) r_rp <= (r_rp == AW'(Depth - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
            if (o_out.valid && o_out.ready) r_sub <= !pop;
        end
    end
endmodule
`default_nettype wire

[hdl/qfp_checker.sv]
`default_nettype none
`include "quic_frame_parser_top_macros.svh"
module qfp_checker (
    input wire             i_clk,
    input wire             i_rst_n,
    input wire             out_valid,
    input wire             out_ready,
    input qfp_pkg::t_res   out_data
);
    `QFP_ASSERT_IMPL(a_err_code, i_clk, i_rst_n, out_valid && out_data.kind == qfp_pkg::K_ERR, out_data.err_code != qfp_pkg::E_NONE && out_data.last)
    `QFP_ASSERT_IMPL(a_done_last, i_clk, i_rst_n, out_valid && out_data.kind == qfp_pkg::K_DONE, out_data.last)
    `QFP_ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    `QFP_ASSERT_IMPL(a_nodata_fields, i_clk, i_rst_n, out_valid && out_data.kind != qfp_pkg::K_HDR, out_data.field_a == '0 && out_data.stream_fin == 1'b0)
endmodule

bind quic_frame_parser_top qfp_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .out_valid(o_out.valid), .out_ready(o_out.ready), .out_data(o_out.data)
);
`default_nettype wire
